// ----- design/kseq_pkg.sv -----
// Shared types and constants for the knock sequence recorder.
package kseq_pkg;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_LISTEN,
    PH_ALIGN,
    PH_EMIT
  } phase_t;

  // Configuration register indexes
  localparam logic [1:0] REG_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_FADE      = 2'd1;
  localparam logic [1:0] REG_TIMEOUT   = 2'd2;

  localparam logic [11:0] THRESHOLD_RST = 12'd100;
  localparam logic [15:0] FADE_RST      = 16'd150;
  localparam logic [15:0] TIMEOUT_RST   = 16'd1200;

  // Controller to datapath
  typedef struct packed {
    logic       shift;
    logic       out_load;
    logic       out_last;
    logic       out_empty;
    logic [4:0] out_pos;
  } ctl_t;

endpackage

// ----- design/kseq_cell.sv -----
// One interval cell of the storage chain.
module kseq_cell #(
  parameter int W = 16
) (
  input  logic         clk,
  input  logic         shift,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] val_r;

  always_ff @(posedge clk) begin
    if (shift) begin
      val_r <= d;
    end
  end

  assign q = val_r;

endmodule

// ----- design/kseq_ctrl.sv -----
// Sequence controller: tick timers, knock count and emission sequencing.
module kseq_ctrl #(
  parameter int MAX_KNOCKS    = 20,
  parameter int INTERVAL_BITS = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_acc,
  input  logic [11:0]     sample,
  input  logic [11:0]     threshold,
  input  logic [15:0]     fade_ticks,
  input  logic [15:0]     timeout_ticks,
  input  logic            out_busy,
  output kseq_pkg::ctl_t  ctl,
  output logic [15:0]     rec_val,
  output logic            in_stall
);

  localparam int CW = $clog2(MAX_KNOCKS + 1);
  localparam logic [CW-1:0] MAXK = CW'(MAX_KNOCKS);
  localparam logic [15:0] CAP = (INTERVAL_BITS < 16) ?
      16'((32'd1 << INTERVAL_BITS) - 32'd1) : 16'hFFFF;

  kseq_pkg::phase_t phase_r, phase_nxt;
  logic [15:0]   elapsed_r, elapsed_nxt;
  logic [15:0]   fade_r, fade_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] align_r, align_nxt;
  logic [CW-1:0] pos_r, pos_nxt;

  logic          knock;
  logic          start;
  logic          ticked;
  logic          rec;
  logic          seq_end;
  logic          emit_fire;
  logic          is_last;
  logic [15:0]   inc;
  logic [CW+4:0] pos_ext;

  assign knock = (sample >= threshold);
  assign inc   = (elapsed_r != 16'hFFFF) ? elapsed_r + 16'd1 : elapsed_r;
  assign rec_val = (inc > CAP) ? CAP : inc;
  assign start  = in_acc && (phase_r == kseq_pkg::PH_IDLE) && knock;
  assign ticked = start || (in_acc && (phase_r == kseq_pkg::PH_LISTEN));

  // Per-tick state update
  always_comb begin
    elapsed_nxt = elapsed_r;
    fade_nxt    = fade_r;
    count_nxt   = count_r;
    rec         = 1'b0;
    if (start) begin
      elapsed_nxt = '0;
      count_nxt   = '0;
      fade_nxt    = fade_ticks;
    end else if (in_acc && (phase_r == kseq_pkg::PH_LISTEN)) begin
      elapsed_nxt = inc;
      if (fade_r != 16'd0) begin
        fade_nxt = fade_r - 16'd1;
      end else if (knock && (count_r < MAXK)) begin
        rec         = 1'b1;
        count_nxt   = count_r + 1'b1;
        elapsed_nxt = '0;
        fade_nxt    = fade_ticks;
      end
    end
  end

  assign seq_end = ticked && (fade_nxt == 16'd0) &&
                   ((elapsed_nxt >= timeout_ticks) || (count_nxt >= MAXK));

  assign emit_fire = (phase_r == kseq_pkg::PH_EMIT) && !out_busy;
  assign is_last   = (count_r == '0) || (pos_r == count_r - 1'b1);

  // Next state
  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      kseq_pkg::PH_IDLE: begin
        if (seq_end) begin
          phase_nxt = kseq_pkg::PH_EMIT;
        end else if (start) begin
          phase_nxt = kseq_pkg::PH_LISTEN;
        end
      end
      kseq_pkg::PH_LISTEN: begin
        if (seq_end) begin
          if ((count_nxt == '0) || (count_nxt == MAXK)) begin
            phase_nxt = kseq_pkg::PH_EMIT;
          end else begin
            phase_nxt = kseq_pkg::PH_ALIGN;
          end
        end
      end
      kseq_pkg::PH_ALIGN: begin
        if (align_r == CW'(1)) begin
          phase_nxt = kseq_pkg::PH_EMIT;
        end
      end
      kseq_pkg::PH_EMIT: begin
        if (emit_fire && is_last) begin
          phase_nxt = kseq_pkg::PH_IDLE;
        end
      end
      default: phase_nxt = kseq_pkg::PH_IDLE;
    endcase
  end

  // Counters for alignment and emission
  always_comb begin
    align_nxt = align_r;
    pos_nxt   = pos_r;
    case (phase_r)
      kseq_pkg::PH_LISTEN: begin
        align_nxt = MAXK - count_nxt;
        pos_nxt   = '0;
      end
      kseq_pkg::PH_ALIGN: begin
        align_nxt = align_r - 1'b1;
        pos_nxt   = '0;
      end
      kseq_pkg::PH_EMIT: begin
        if (emit_fire) begin
          pos_nxt = pos_r + 1'b1;
        end
      end
      default: pos_nxt = '0;
    endcase
  end

  // Outputs
  assign pos_ext = {5'd0, pos_r};

  always_comb begin
    ctl.shift     = rec;
    ctl.out_load  = 1'b0;
    ctl.out_last  = is_last;
    ctl.out_empty = (count_r == '0);
    ctl.out_pos   = pos_ext[4:0];
    in_stall      = 1'b0;
    case (phase_r)
      kseq_pkg::PH_ALIGN: begin
        ctl.shift = 1'b1;
        in_stall  = 1'b1;
      end
      kseq_pkg::PH_EMIT: begin
        ctl.shift    = emit_fire;
        ctl.out_load = emit_fire;
        in_stall     = 1'b1;
      end
      default: begin
        ctl.shift = rec;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= kseq_pkg::PH_IDLE;
      elapsed_r <= '0;
      fade_r    <= '0;
      count_r   <= '0;
      align_r   <= '0;
      pos_r     <= '0;
    end else begin
      phase_r   <= phase_nxt;
      elapsed_r <= elapsed_nxt;
      fade_r    <= fade_nxt;
      count_r   <= count_nxt;
      align_r   <= align_nxt;
      pos_r     <= pos_nxt;
    end
  end

endmodule

// ----- design/knock_sequence_recorder.sv -----
// Top level of the knock sequence recorder: config registers, cell chain, output register.
//
// Usage
//   Input channel (in_valid/in_stall/in_sample): one piezo word per millisecond tick.
//   A word is taken on a rising edge with in_valid high and in_stall low.
//   Result channel (out_valid/out_stall/out_*): one word per stored interval, in knock
//   order, out_last on the final word; a sequence with no knock after the first gives a
//   single word with out_empty_res set and out_interval zero.
//   Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): cfg_ready is always high;
//   index 0 threshold, 1 fade ticks, 2 timeout ticks. Write only while idle.
// Timing
//   The input does not stall while recording. When a tick ends a sequence the
//   input stalls: the cell chain first shifts MAX_KNOCKS - count times to bring the
//   first interval to cell 0 (one cell per cycle), then hands one word per cycle to
//   the output register while a held word does not stall it (out_stall). The input
//   reopens once the last word is in the register.
// Reset
//   rst_n low clears phase, timers and count; registers return to 100/150/1200.
//   out_stall holds the output register and pauses emission; the payload holds steady.
module knock_sequence_recorder #(
  parameter int MAX_KNOCKS    = 20,
  parameter int INTERVAL_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [11:0] in_sample,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_interval,
  output logic [4:0]  out_position,
  output logic        out_last,
  output logic        out_empty_res,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int IB = INTERVAL_BITS;

  // Configuration registers
  logic [11:0] threshold_r;
  logic [15:0] fade_r;
  logic [15:0] timeout_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= kseq_pkg::THRESHOLD_RST;
      fade_r      <= kseq_pkg::FADE_RST;
      timeout_r   <= kseq_pkg::TIMEOUT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        kseq_pkg::REG_THRESHOLD: threshold_r <= cfg_data[11:0];
        kseq_pkg::REG_FADE:      fade_r      <= cfg_data;
        kseq_pkg::REG_TIMEOUT:   timeout_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Controller
  kseq_pkg::ctl_t ctl;
  logic [15:0]    rec_val;
  logic           in_acc;
  logic           out_valid_r;

  assign in_acc = in_valid && !in_stall;

  kseq_ctrl #(
    .MAX_KNOCKS    (MAX_KNOCKS),
    .INTERVAL_BITS (INTERVAL_BITS)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_acc        (in_acc),
    .sample        (in_sample),
    .threshold     (threshold_r),
    .fade_ticks    (fade_r),
    .timeout_ticks (timeout_r),
    .out_busy      (out_valid_r && out_stall),
    .ctl           (ctl),
    .rec_val       (rec_val),
    .in_stall      (in_stall)
  );

  // Cell chain: new intervals enter at the tail, words leave from cell 0
  logic [IB+15:0] tail_ext;
  logic [IB-1:0]  cell_q [MAX_KNOCKS];

  assign tail_ext = {{IB{1'b0}}, rec_val};

  for (genvar i = 0; i < MAX_KNOCKS; i++) begin : g_cell
    logic [IB-1:0] d;
    if (i == MAX_KNOCKS - 1) begin : g_tail
      assign d = tail_ext[IB-1:0];
    end else begin : g_mid
      assign d = cell_q[i+1];
    end
    kseq_cell #(.W(IB)) u_cell (
      .clk   (clk),
      .shift (ctl.shift),
      .d     (d),
      .q     (cell_q[i])
    );
  end

  // Output register
  logic [IB+15:0] head_ext;
  logic [15:0]    interval_r;
  logic [4:0]     position_r;
  logic           last_r;
  logic           empty_r;

  assign head_ext = {16'd0, cell_q[0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      interval_r <= ctl.out_empty ? 16'd0 : head_ext[15:0];
      position_r <= ctl.out_pos;
      last_r     <= ctl.out_last;
      empty_r    <= ctl.out_empty;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_interval  = interval_r;
  assign out_position  = position_r;
  assign out_last      = last_r;
  assign out_empty_res = empty_r;

endmodule

// ----- sim/tb_knock_sequence_recorder.sv -----
// Testbench for the knock sequence recorder: scoreboard class with tick predictor, drivers.

typedef struct packed {
  logic [15:0] interval;
  logic [4:0]  position;
  logic        is_last;
  logic        is_empty;
} knock_word_t;

class knock_scoreboard;
  localparam int MAX_KNOCKS   = 20;
  localparam int REPORT_LIMIT = 10;

  logic [11:0]      threshold;
  logic [15:0]      fade_ticks;
  logic [15:0]      timeout_ticks;
  kseq_pkg::phase_t phase;
  logic [15:0]      elapsed;
  logic [15:0]      fade_left;
  int unsigned      knock_count;
  logic [15:0]      intervals [MAX_KNOCKS];
  knock_word_t      due_words [$];
  int unsigned      mismatches;

  function new();
    threshold     = kseq_pkg::THRESHOLD_RST;
    fade_ticks    = kseq_pkg::FADE_RST;
    timeout_ticks = kseq_pkg::TIMEOUT_RST;
    phase         = kseq_pkg::PH_IDLE;
    elapsed       = '0;
    fade_left     = '0;
    knock_count   = 0;
    mismatches    = 0;
  endfunction

  function void set_reg(input logic [1:0] idx, input logic [15:0] data);
    case (idx)
      kseq_pkg::REG_THRESHOLD: threshold     = data[11:0];
      kseq_pkg::REG_FADE:      fade_ticks    = data;
      kseq_pkg::REG_TIMEOUT:   timeout_ticks = data;
      default: ;
    endcase
  endfunction

  function bit listening();
    return phase == kseq_pkg::PH_LISTEN;
  endfunction

  function int unsigned pending();
    return due_words.size();
  endfunction

  // Sequence over: queue one word per stored interval, or the lone empty marker.
  function void emit_words();
    knock_word_t w;
    phase     = kseq_pkg::PH_IDLE;
    fade_left = '0;
    if (knock_count == 0) begin
      w = '{interval: 16'd0, position: 5'd0, is_last: 1'b1, is_empty: 1'b1};
      due_words.push_back(w);
    end else begin
      for (int i = 0; i < knock_count; i++) begin
        w.interval = intervals[i];
        w.position = 5'(i);
        w.is_last  = (i + 1 == knock_count);
        w.is_empty = 1'b0;
        due_words.push_back(w);
      end
    end
  endfunction

  // One accepted sample is one millisecond tick.
  function void note_sample(input logic [11:0] s);
    if (phase != kseq_pkg::PH_LISTEN) begin
      if (s < threshold) return;
      knock_count = 0;
      elapsed     = '0;
      fade_left   = fade_ticks;
      phase       = kseq_pkg::PH_LISTEN;
    end else begin
      if (elapsed != 16'hFFFF) elapsed = elapsed + 16'd1;
      if (fade_left != 16'd0) begin
        fade_left = fade_left - 16'd1;
      end else if (s >= threshold && knock_count < MAX_KNOCKS) begin
        // 16 bit intervals: the cap equals the timer's own ceiling
        intervals[knock_count] = elapsed;
        knock_count++;
        elapsed   = '0;
        fade_left = fade_ticks;
      end
    end
    if (fade_left == 16'd0 && (elapsed >= timeout_ticks || knock_count >= MAX_KNOCKS))
      emit_words();
  endfunction

  function void check_word(input logic [15:0] iv, input logic [4:0] pos,
                           input logic lst, input logic emp);
    knock_word_t want;
    if (due_words.size() == 0) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display("unexpected word: interval %0d position %0d last %0b empty %0b",
                 iv, pos, lst, emp);
      return;
    end
    want = due_words.pop_front();
    if (iv !== want.interval || pos !== want.position ||
        lst !== want.is_last || emp !== want.is_empty) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display("word mismatch: expected %0d/%0d/%0b/%0b, got %0d/%0d/%0b/%0b",
                 want.interval, want.position, want.is_last, want.is_empty,
                 iv, pos, lst, emp);
    end
  endfunction
endclass

module tb_knock_sequence_recorder;

  localparam int MAX_KNOCKS     = 20;
  // cells shift up to MAX_KNOCKS times, then one word per cycle unless stalled: quiet time after the last word
  localparam int SETTLE_CYCLES  = 2 * MAX_KNOCKS + 8;
  localparam int HOLD_CYCLES    = 300;
  localparam int CYCLE_LIMIT    = 2_000_000;
  localparam int RANDOM_PHASES  = 8;
  localparam int WORDS_PER_PHASE = 32;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [11:0] in_sample;
  logic        out_valid;
  logic        out_stall;
  logic [15:0] out_interval;
  logic [4:0]  out_position;
  logic        out_last;
  logic        out_empty_res;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  knock_scoreboard sb;

  // Idle controls shared between the sender, the receiver and the sequencer
  bit          in_calm;
  bit          out_calm;
  bit          hold_off_req;
  int unsigned cycles;

  knock_sequence_recorder dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_sample     (in_sample),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_interval  (out_interval),
    .out_position  (out_position),
    .out_last      (out_last),
    .out_empty_res (out_empty_res),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Knock with odds 1 in 'odds', otherwise a quiet reading; a zero threshold makes
  // every reading a knock.
  function automatic logic [11:0] pick_sample(input logic [11:0] thr, input int unsigned odds);
    if (thr == 12'd0 || $urandom_range(1, odds) == 1)
      return 12'($urandom_range(int'(thr), 4095));
    if ($urandom_range(0, 19) == 0) return 12'd0;
    return 12'($urandom_range(0, int'(thr) - 1));
  endfunction

  // Offer one sample word; returns at the edge that takes it, valid still high so that
  // a back-to-back word follows without a dip.
  task automatic send_sample(input logic [11:0] s);
    int unsigned gap;
    gap = in_calm ? 0 : idle_len();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_sample(s);
  endtask

  // Drop valid and sit until every predicted word has come out.
  task automatic wait_all_words();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Finish any open sequence with quiet ticks, then let the block go idle.
  task automatic settle();
    bit saved;
    saved   = in_calm;
    in_calm = 1'b1;
    while (sb.listening()) send_sample(12'd0);
    in_calm = saved;
    wait_all_words();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, data);
  endtask

  task automatic apply_config(input logic [11:0] thr, input logic [15:0] fade,
                              input logic [15:0] tmo);
    write_reg(kseq_pkg::REG_THRESHOLD, {4'd0, thr});
    write_reg(kseq_pkg::REG_FADE, fade);
    write_reg(kseq_pkg::REG_TIMEOUT, tmo);
    cfg_valid <= 1'b0;
  endtask

  // Result side: random stall runs, plus one long hold-off on request.
  initial begin : receiver
    int unsigned run;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        out_stall <= 1'b1;
        for (int c = 0; c < HOLD_CYCLES; c++) @(posedge clk);
        hold_off_req = 1'b0;
        out_stall <= 1'b0;
      end else begin
        run = out_calm ? 0 : idle_len();
        if (run == 0) begin
          out_stall <= 1'b0;
        end else begin
          out_stall <= 1'b1;
          repeat (run - 1) @(posedge clk);
        end
      end
    end
  end

  // Every word taken on the result channel goes to the scoreboard.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_word(out_interval, out_position, out_last, out_empty_res);
  end

  initial begin : watchdog
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : sequencer
    logic [11:0] thr;
    logic [15:0] fade;
    logic [15:0] tmo;
    logic [11:0] s;
    int unsigned odds;
    int unsigned done;
    bit          counts;
    bit          paused;

    sb           = new();
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_sample    = 12'd0;
    cfg_valid    = 1'b0;
    cfg_index    = kseq_pkg::REG_THRESHOLD;
    cfg_data     = 16'd0;
    in_calm      = 1'b0;
    out_calm     = 1'b0;
    hold_off_req = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: one below the threshold, one exactly on it; the sequence then
    // runs out its fade and timeout with no second knock, giving the empty word.
    send_sample(12'd99);
    send_sample(12'd100);
    settle();

    // Mid threshold, no fade: a knock right after the start, then a timeout of 3.
    apply_config(12'h800, 16'd0, 16'd3);
    send_sample(12'h7FF);
    send_sample(12'h800);
    send_sample(12'hFFF);
    send_sample(12'd0);
    send_sample(12'd0);
    send_sample(12'd0);
    settle();

    // Zero threshold, no fade, longest timeout: every tick knocks until the store fills.
    apply_config(12'd0, 16'd0, 16'hFFFF);
    repeat (MAX_KNOCKS + 1) send_sample(12'd0);
    settle();

    // Timeout of zero: the sequence closes at the first end check after the fade.
    apply_config(12'hFFF, 16'd1, 16'd0);
    send_sample(12'hFFF);
    send_sample(12'd0);
    settle();

    // Fade equal to the timeout: the timer meets the timeout as the fade runs out.
    in_calm  = 1'b1;
    out_calm = 1'b1;
    apply_config(12'hFFF, 16'd16, 16'd16);
    send_sample(12'hFFF);
    settle();

    // Timeout under the fade: the sequence ends as the fade runs out, so the knock after it opens a new one.
    apply_config(12'hFFF, 16'd12, 16'd4);
    send_sample(12'hFFF);
    repeat (12) send_sample(12'd0);
    send_sample(12'hFFF);
    settle();

    // Random phases: knock sequences with random content, spaced to beat the timeout
    // most of the time, one phase of sparse noise.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p == 0) thr = 12'd0;
      else if (p == 1) thr = 12'hFFF;
      else thr = 12'($urandom_range(1, 4094));
      fade = (p == 1 || p == 3) ? 16'd0 : 16'($urandom_range(0, 12));
      tmo  = (p == 1) ? 16'd1 : 16'($urandom_range(2, 40));
      odds = (p == 5) ? 60 : $urandom_range(2, int'(tmo) / 2 + 2);
      in_calm  = (p == 2) || ($urandom_range(0, 3) == 0);
      out_calm = ($urandom_range(0, 3) == 0);
      apply_config(thr, fade, tmo);
      // long receiver hold-off while the sender keeps offering: fills the block
      if (p == 2) hold_off_req = 1'b1;
      done   = 0;
      paused = 1'b0;
      while (done < WORDS_PER_PHASE) begin
        if (p == 4 && !paused && done >= WORDS_PER_PHASE / 2) begin
          wait_all_words();
          paused = 1'b1;
        end
        s      = pick_sample(thr, odds);
        // quiet ticks while idle are ignored by the block and not counted
        counts = sb.listening() || (s >= thr);
        send_sample(s);
        if (counts) done++;
      end
      settle();
    end

    wait_all_words();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
